### rtl/tlb_page_table_translator_unit_defines.svh
// assertion macros shared by the translator rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef TLB_PAGE_TABLE_TRANSLATOR_UNIT_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition must never hold outside reset
`define TPT_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tpt check failed");
// antecedent implies consequent in the same cycle
`define TPT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpt check failed");
// antecedent implies consequent in the next cycle
`define TPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpt check failed");
`else
`define TPT_ASSERT_NEVER(lbl, clk, rst, cond)
`define TPT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/tpt_pkg.sv
// shared constants and types of the address translator
// no dependencies
package tpt_pkg;

  localparam int unsigned VA_W            = 16;
  localparam int unsigned FRAME_W         = 8;
  localparam int unsigned PAGE_OUT_W      = 8;
  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_COUNT_DEF  = 256;
  localparam int unsigned OFFSET_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  typedef logic [VA_W-1:0]       va_t;
  typedef logic [FRAME_W-1:0]    frame_t;
  typedef logic [PAGE_OUT_W-1:0] page_out_t;

endpackage

### rtl/tpt_ifs.sv
// valid/ready channel interfaces for request and response items
// depends on tpt_pkg
interface tpt_req_if;
  logic         valid;
  logic         ready;
  tpt_pkg::va_t virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink (input valid, input virtual_address, output ready);
endinterface

interface tpt_rsp_if;
  logic               valid;
  logic               ready;
  tpt_pkg::va_t       physical_address;
  tpt_pkg::frame_t    frame;
  tpt_pkg::page_out_t virt_page;
  logic               tlb_hit;
  logic               page_fault;

  modport source (output valid, output physical_address, output frame,
                  output virt_page, output tlb_hit, output page_fault,
                  input ready);
  modport sink (input valid, input physical_address, input frame,
                input virt_page, input tlb_hit, input page_fault,
                output ready);
endinterface

### rtl/tpt_front.sv
// front end: accepts request items and reduces the page number modulo page count
// depends on tpt_pkg and tpt_req_if
module tpt_front #(
  parameter int unsigned PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF,
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT)
) (
  input  logic                             clk,
  input  logic                             rst,
  tpt_req_if.sink                          req,
  input  logic                             clearing,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [tpt_pkg::VA_W+PAGE_W-1:0]  q_data
);

  localparam int unsigned VPN_W       = (tpt_pkg::VA_W > OFFSET_BITS) ?
                                        (tpt_pkg::VA_W - OFFSET_BITS) : 1;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / PAGE_COUNT;

  logic             s_valid;
  tpt_pkg::va_t     s_va;
  logic [31:0]      s_prod;
  logic [VPN_W-1:0] vpn_in;
  logic [VPN_W-1:0] s_vpn;
  logic [VPN_W-1:0] quot;
  logic [VPN_W-1:0] quot_mul;
  logic [VPN_W-1:0] rem_est;
  logic [VPN_W-1:0] rem_fix;
  logic [PAGE_W-1:0] page;
  logic             in_fire;

  assign vpn_in    = VPN_W'(req.virtual_address >> OFFSET_BITS);
  assign req.ready = !clearing && (!s_valid || q_push);
  assign in_fire   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_fire) begin
      s_valid <= 1'b1;
    end else if (q_push) begin
      s_valid <= 1'b0;
    end
  end

  // reciprocal product registered, remainder fixed up next cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_va   <= req.virtual_address;
      s_prod <= 32'(vpn_in) * 32'(RECIP);
    end
  end

  always_comb begin
    s_vpn    = VPN_W'(s_va >> OFFSET_BITS);
    quot     = VPN_W'(s_prod >> RECIP_SHIFT);
    quot_mul = VPN_W'(32'(quot) * 32'(PAGE_COUNT));
    rem_est  = s_vpn - quot_mul;
    if (32'(rem_est) >= 32'(PAGE_COUNT)) begin
      rem_fix = rem_est - VPN_W'(PAGE_COUNT);
    end else begin
      rem_fix = rem_est;
    end
    page = PAGE_W'(rem_fix);
  end

  assign q_push = s_valid && !q_full;
  assign q_data = {s_va, page};

endmodule

### rtl/tpt_queue.sv
// short fifo between front end and back end
// depends on nothing
module tpt_queue #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/tpt_back.sv
// back end: tlb lookup, page-table read and write-back, output register
// depends on tpt_pkg and tpt_rsp_if
module tpt_back #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF,
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [tpt_pkg::VA_W+PAGE_W-1:0] q_data,
  output logic                            q_pop,
  output logic                            clearing,
  tpt_rsp_if.source                       rsp
);

  localparam int unsigned TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int unsigned FRAME_W   = tpt_pkg::FRAME_W;

  typedef enum logic [2:0] {
    ST_CLEAR   = 3'b001,
    ST_LOOK    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic            tlb_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0] tlb_page [TLB_ENTRIES];
  tpt_pkg::frame_t tlb_frame [TLB_ENTRIES];
  logic [TLB_IDX_W-1:0] tlb_ptr;
  tpt_pkg::frame_t next_free_frame;

  // page table word: present bit over frame
  logic [FRAME_W:0] pt_mem [PAGE_COUNT];
  logic [FRAME_W:0] pt_rdata;
  logic             pt_we;
  logic [PAGE_W-1:0] pt_waddr;
  logic [FRAME_W:0] pt_wdata;
  logic [PAGE_W-1:0] clr_idx;

  tpt_pkg::va_t    q_va;
  logic [PAGE_W-1:0] q_page;
  tpt_pkg::va_t    cur_va;
  logic [PAGE_W-1:0] cur_page;
  logic            look_hit;
  tpt_pkg::frame_t look_frame;
  logic            hit_c;
  tpt_pkg::frame_t frame_c;

  logic            resolve_fire;
  logic            present;
  logic            res_fault;
  tpt_pkg::frame_t res_frame;
  logic [31:0]     pa_full;

  assign q_va     = q_data[tpt_pkg::VA_W+PAGE_W-1:PAGE_W];
  assign q_page   = q_data[PAGE_W-1:0];
  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_LOOK) && q_valid;
  assign resolve_fire = (state == ST_RESOLVE) && (!rsp.valid || rsp.ready);

  // parallel compare, lowest matching slot wins
  always_comb begin
    hit_c   = 1'b0;
    frame_c = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_page[i] == q_page)) begin
        hit_c   = 1'b1;
        frame_c = tlb_frame[i];
      end
    end
  end

  always_comb begin
    present   = pt_rdata[FRAME_W];
    res_fault = !look_hit && !present;
    if (look_hit) begin
      res_frame = look_frame;
    end else if (present) begin
      res_frame = pt_rdata[FRAME_W-1:0];
    end else begin
      res_frame = next_free_frame;
    end
    pa_full = (32'(res_frame) << OFFSET_BITS) | 32'(cur_va[OFFSET_BITS-1:0]);
  end

  always_comb begin
    pt_we    = clearing || (resolve_fire && res_fault);
    pt_waddr = clearing ? clr_idx : cur_page;
    pt_wdata = clearing ? '0 : {1'b1, next_free_frame};
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (q_pop) begin
      pt_rdata <= pt_mem[q_page];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (q_valid) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (resolve_fire) begin
          state_next = ST_LOOK;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_idx         <= '0;
      tlb_ptr         <= '0;
      next_free_frame <= '0;
      rsp.valid       <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (resolve_fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (resolve_fire && !look_hit) begin
        tlb_valid[tlb_ptr] <= 1'b1;
        tlb_ptr <= (tlb_ptr == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : tlb_ptr + 1'b1;
      end
      if (resolve_fire && res_fault) begin
        next_free_frame <= next_free_frame + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_va     <= q_va;
      cur_page   <= q_page;
      look_hit   <= hit_c;
      look_frame <= frame_c;
    end
    if (resolve_fire && !look_hit) begin
      tlb_page[tlb_ptr]  <= cur_page;
      tlb_frame[tlb_ptr] <= res_frame;
    end
    if (resolve_fire) begin
      rsp.physical_address <= tpt_pkg::VA_W'(pa_full);
      rsp.frame            <= res_frame;
      rsp.virt_page        <= tpt_pkg::PAGE_OUT_W'(cur_page);
      rsp.tlb_hit          <= look_hit;
      rsp.page_fault       <= res_fault;
    end
  end

endmodule

### rtl/tlb_page_table_translator_unit.sv
// top level of the virtual-to-physical address translator
// depends on tpt_pkg, tpt_ifs, tpt_front, tpt_queue, tpt_back and the defines header

// Translates one 16-bit virtual address per item into a physical address
// through a fully associative TLB backed by a demand-paged page table. The
// page number is (address >> OFFSET_BITS) modulo PAGE_COUNT; a TLB miss reads
// the page table, and a page-table miss raises page_fault and hands out the
// next frame from an 8-bit wrapping counter. Every miss refills the TLB slot
// named by a round-robin pointer. After reset the page table is swept clear,
// one entry a cycle, for PAGE_COUNT entries (256 by default); no item is taken
// in that time. Per item the back end has a look step for the TLB compare and
// the registered page-table read, then a resolve step (held while a response
// waits) that writes back to the page table and TLB for the next item to see.
// The front end registers each item, and a two-entry queue lets requests keep
// arriving while a response waits in the output register.
`include "tlb_page_table_translator_unit_defines.svh"

module tlb_page_table_translator_unit #(
  parameter int unsigned TLB_ENTRIES = tpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT  = tpt_pkg::PAGE_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = tpt_pkg::OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tpt_req_if.sink   req,
  tpt_rsp_if.source rsp
);

  localparam int unsigned PAGE_W = $clog2(PAGE_COUNT);
  localparam int unsigned QW     = tpt_pkg::VA_W + PAGE_W;

  // page-table clearing pass in progress
  logic          clearing;
  // queue hand-off between the two halves
  logic          q_push;
  logic          q_full;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic [QW-1:0] q_pop_data;
  logic          q_valid;

  // front end: take the item, split it, reduce the page number
  tpt_front #(
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // decoupling queue
  tpt_queue #(
    .WIDTH (QW),
    .DEPTH (tpt_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  // back end: tlb, page table, frame allocation, response register
  tpt_back #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  // a response never claims both a tlb hit and a fault
  `TPT_ASSERT_NEVER(a_flags_exclusive, clk, rst, rsp.valid && rsp.tlb_hit && rsp.page_fault)
  // no request taken while the page table is being cleared
  `TPT_ASSERT_NEVER(a_no_accept_clearing, clk, rst, clearing && req.valid && req.ready)
  // leaving reset always starts the clearing pass
  `TPT_ASSERT_IMPLIES(a_clear_after_reset, clk, rst, $fell(rst), clearing)
  // a pop is always followed by a resolve cycle without one
  `TPT_ASSERT_NEXT(a_queue_sane, clk, rst, q_pop, !q_pop)

endmodule
